>>> sv/joystick_gesture_decoder_assert.svh
// assertion macros shared by the joystick gesture decoder
// expects clk_i and rst_ni in the scope of each use
`ifndef JOYSTICK_GESTURE_DECODER_ASSERT_SVH
`define JOYSTICK_GESTURE_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JGD_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jgd assertion failed");

// next-cycle implication, checked outside reset
`define JGD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jgd assertion failed");

`endif

>>> sv/jgd_pkg.sv
// shared types and constants of the joystick gesture decoder
// used by the classifier front, the region queue, the gesture back and the top level
package jgd_pkg;

  // sample and arithmetic sizes
  localparam int ADC_LEVELS = 4096;
  localparam int SAMPLE_W   = 12;
  localparam int CENTER     = (ADC_LEVELS - 1) / 2;
  localparam int ABS_W      = SAMPLE_W;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int RADIUS_W   = 24;
  localparam int TAN_W      = 16;
  localparam int TAN_FRAC   = 16;
  localparam int PROD_W     = TAN_W + ABS_W;

  // gesture sequence
  localparam int MAX_GESTURE_LEN = 8;
  localparam int CODE_ENTRIES    = 4;
  localparam int NUM_CODE_REGS   = 4;
  localparam int DIR_W           = 2;
  localparam int LEN_W           = 4;
  localparam int SYM_W           = 8;
  localparam int CODE_DIRS       = 8;
  localparam int CODE_W          = SYM_W + LEN_W + CODE_DIRS * DIR_W;

  // region queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 24'd1047553;
  localparam logic [TAN_W-1:0]    TANGENT_RESET = 16'd45889;
  localparam logic [CODE_W-1:0]   CODE0_RESET   = 28'd101842948;
  localparam logic [CODE_W-1:0]   CODE1_RESET   = 28'd103022739;
  localparam logic [CODE_W-1:0]   CODE2_RESET   = 28'd104071366;
  localparam logic [CODE_W-1:0]   CODE3_RESET   = 28'd0;

  typedef enum logic [2:0] {
    REGION_RIGHT   = 3'd0,
    REGION_UP      = 3'd1,
    REGION_LEFT    = 3'd2,
    REGION_DOWN    = 3'd3,
    REGION_CENTRE  = 3'd4,
    REGION_BETWEEN = 3'd5
  } region_e;

  typedef enum logic [2:0] {
    REG_RADIUS  = 3'd0,
    REG_TANGENT = 3'd1,
    REG_CODE0   = 3'd2,
    REG_CODE1   = 3'd3,
    REG_CODE2   = 3'd4,
    REG_CODE3   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [SYM_W-1:0]           symbol;
    logic [LEN_W-1:0]           length;
    logic [CODE_DIRS*DIR_W-1:0] dirs;
  } code_entry_t;

  typedef code_entry_t [NUM_CODE_REGS-1:0] code_table_t;

  // head of the region queue as seen by the back end
  typedef struct packed {
    logic    valid;
    region_e region;
  } q_head_t;

  // fill status of the region queue
  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

>>> sv/jgd_front.sv
// classifier front: centres the samples and sorts the stick into a region
// depends on jgd_pkg
module jgd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [jgd_pkg::SAMPLE_W-1:0]  x_sample_i,
  input  logic [jgd_pkg::SAMPLE_W-1:0]  y_sample_i,
  input  logic [jgd_pkg::RADIUS_W-1:0]  radius_sq_i,
  input  logic [jgd_pkg::TAN_W-1:0]     tangent_i,
  output logic                          cls_valid_o,
  output jgd_pkg::region_e              cls_region_o
);
  import jgd_pkg::*;

  logic signed [SAMPLE_W:0] dx, dy;
  logic [ABS_W-1:0]  adx, ady;
  logic [SQ_W-1:0]   sqx, sqy;
  logic [SUM_W-1:0]  sum_d;
  logic [PROD_W-1:0] prod_x_d, prod_y_d;

  logic              valid_q;
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [ABS_W-1:0]  adx_q, ady_q;
  logic              dx_neg_q, dy_neg_q;

  logic [PROD_W-1:0] ax_sh, ay_sh;
  logic              dx_zero, dy_zero;
  logic              centred, right, up, left, down;

  // stage one: offsets, squares and tangent products
  assign dx  = $signed({1'b0, x_sample_i}) - $signed((SAMPLE_W+1)'(CENTER));
  assign dy  = $signed({1'b0, y_sample_i}) - $signed((SAMPLE_W+1)'(CENTER));
  assign adx = dx[SAMPLE_W] ? ABS_W'(-dx) : ABS_W'(dx);
  assign ady = dy[SAMPLE_W] ? ABS_W'(-dy) : ABS_W'(dy);

  assign sqx      = SQ_W'(adx) * SQ_W'(adx);
  assign sqy      = SQ_W'(ady) * SQ_W'(ady);
  assign sum_d    = SUM_W'(sqx) + SUM_W'(sqy);
  assign prod_x_d = PROD_W'(tangent_i) * PROD_W'(adx);
  assign prod_y_d = PROD_W'(tangent_i) * PROD_W'(ady);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sum_q    <= sum_d;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      adx_q    <= adx;
      ady_q    <= ady;
      dx_neg_q <= dx[SAMPLE_W];
      dy_neg_q <= dy[SAMPLE_W];
    end
  end

  // stage two: strict compares, so sector edges fall between
  assign ax_sh   = PROD_W'({adx_q, TAN_FRAC'(0)});
  assign ay_sh   = PROD_W'({ady_q, TAN_FRAC'(0)});
  assign dx_zero = (adx_q == '0);
  assign dy_zero = (ady_q == '0);
  assign centred = sum_q < SUM_W'(radius_sq_i);
  assign right   = !dx_neg_q && (ay_sh < prod_x_q);
  assign up      = !dy_neg_q && (ax_sh < prod_y_q);
  assign left    = (dx_neg_q || dx_zero) && (ay_sh < prod_x_q);
  assign down    = (dy_neg_q || dy_zero) && (ax_sh < prod_y_q);

  always_comb begin
    priority if (centred)            cls_region_o = REGION_CENTRE;
    else if (dx_zero && dy_zero)     cls_region_o = REGION_RIGHT;
    else if (right)                  cls_region_o = REGION_RIGHT;
    else if (up)                     cls_region_o = REGION_UP;
    else if (left)                   cls_region_o = REGION_LEFT;
    else if (down)                   cls_region_o = REGION_DOWN;
    else                             cls_region_o = REGION_BETWEEN;
  end

  assign cls_valid_o = valid_q;

endmodule

>>> sv/jgd_queue.sv
// short region queue between the classifier front and the gesture back
// depends on jgd_pkg
module jgd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jgd_pkg::region_e  push_region_i,
  input  logic              pop_i,
  output jgd_pkg::q_head_t  head_o,
  output jgd_pkg::q_stat_t  stat_o
);
  import jgd_pkg::*;

  region_e           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_region_i;
    end
  end

  assign head_o.valid  = (count_q != '0);
  assign head_o.region = slot_q[rd_ptr_q];
  assign stat_o.full   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.count  = count_q;

endmodule

>>> sv/jgd_back.sv
// gesture back end: region tracking, sequence store, code match, result register
// depends on jgd_pkg
module jgd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  jgd_pkg::q_head_t            head_i,
  output logic                        pop_o,
  input  jgd_pkg::code_table_t        codes_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output jgd_pkg::region_e            region_o,
  output logic                        match_found_o,
  output logic [jgd_pkg::SYM_W-1:0]   match_symbol_o
);
  import jgd_pkg::*;

  region_e          cur_region_q, cur_region_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [DIR_W-1:0] sym_q [MAX_GESTURE_LEN];

  logic             out_valid_q, out_valid_d;
  region_e          out_region_q;
  logic             out_found_q;
  logic [SYM_W-1:0] out_symbol_q;

  logic             out_free, take, store_dir;
  logic             found;
  logic [SYM_W-1:0] symbol;
  logic [CODE_ENTRIES-1:0] hit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_i.valid && out_free;
  assign take     = pop_o && (head_i.region != REGION_BETWEEN) &&
                    (head_i.region != cur_region_q);

  // compare the stored sequence against each enabled code
  always_comb begin
    for (int k = 0; k < CODE_ENTRIES; k++) begin
      hit[k] = (codes_i[k].length != '0) && (codes_i[k].length == len_q);
      for (int i = 0; i < MAX_GESTURE_LEN; i++) begin
        if ((LEN_W'(i) < codes_i[k].length) &&
            (codes_i[k].dirs[DIR_W*i +: DIR_W] != sym_q[i])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // lowest entry wins
  always_comb begin
    found  = 1'b0;
    symbol = '0;
    for (int k = CODE_ENTRIES - 1; k >= 0; k--) begin
      if (hit[k] && !ovf_q && (len_q != '0)) begin
        found  = 1'b1;
        symbol = codes_i[k].symbol;
      end
    end
  end

  always_comb begin
    cur_region_d = cur_region_q;
    len_d        = len_q;
    ovf_d        = ovf_q;
    store_dir    = 1'b0;
    if (take) begin
      cur_region_d = head_i.region;
      if (head_i.region == REGION_CENTRE) begin
        len_d = '0;
        ovf_d = 1'b0;
      end else if (len_q >= LEN_W'(MAX_GESTURE_LEN)) begin
        ovf_d = 1'b1;
      end else begin
        store_dir = 1'b1;
        len_d     = len_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_region_q <= REGION_CENTRE;
      len_q        <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_region_q <= cur_region_d;
      len_q        <= len_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_GESTURE_LEN; i++) begin
      if (store_dir && (len_q == LEN_W'(i))) begin
        sym_q[i] <= DIR_W'(head_i.region);
      end
    end
    if (take) begin
      out_region_q <= head_i.region;
      out_found_q  <= (head_i.region == REGION_CENTRE) && found;
      out_symbol_q <= (head_i.region == REGION_CENTRE) ? symbol : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign region_o       = out_region_q;
  assign match_found_o  = out_found_q;
  assign match_symbol_o = out_symbol_q;

endmodule

>>> sv/joystick_gesture_decoder.sv
// top level of the joystick gesture decoder: config registers and block wiring
// depends on jgd_pkg, jgd_front, jgd_queue, jgd_back and the assertion header
//
// usage
// - input channel: in_valid_i with x_sample_i / y_sample_i, one joystick sample pair
//   per item, taken at a rising edge with in_valid_i high and in_stall_o low
// - output channel: out_valid_o with region_o, match_found_o, match_symbol_o; an
//   item is taken when out_stall_i is low. an input item makes zero or one result
// - config: apb-style, six registers at byte addresses 0x00..0x14 (radius squared,
//   sector tangent, four gesture codes); write only while the block is idle
// - throughput: one item per cycle while the receiver does not stall; the back end
//   gesture state update handles one queued region per cycle while it may pop
// - path: an item passes the classifier register stage, a region queue slot, then
//   the back end result register, which holds any result that it makes
// - a stalled receiver holds the result register; the back end stops popping,
//   the four-entry region queue fills and in_stall_o rises once the queue plus
//   the classifier stage would have no room left
// - reset: registers go to their default values, the stick counts as centred,
//   the gesture sequence is empty; no clearing pass is needed
`include "joystick_gesture_decoder_assert.svh"

module joystick_gesture_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [jgd_pkg::SAMPLE_W-1:0]  x_sample_i,
  input  logic [jgd_pkg::SAMPLE_W-1:0]  y_sample_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    region_o,
  output logic                          match_found_o,
  output logic [jgd_pkg::SYM_W-1:0]     match_symbol_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jgd_pkg::ADDR_W-1:0]    paddr,
  input  logic [jgd_pkg::DATA_W-1:0]    pwdata,
  output logic [jgd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import jgd_pkg::*;

  // configuration registers
  logic [RADIUS_W-1:0] radius_q;
  logic [TAN_W-1:0]    tangent_q;
  code_table_t         codes_q;
  reg_idx_e            cfg_idx;
  logic                cfg_wr;

  // block wiring
  logic     in_accept;
  logic     cls_valid;
  region_e  cls_region;
  logic     q_push, q_pop;
  q_head_t  q_head;
  q_stat_t  q_stat;
  region_e  out_region;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RESET;
      tangent_q  <= TANGENT_RESET;
      codes_q[0] <= CODE0_RESET;
      codes_q[1] <= CODE1_RESET;
      codes_q[2] <= CODE2_RESET;
      codes_q[3] <= CODE3_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS:  radius_q   <= pwdata[RADIUS_W-1:0];
        REG_TANGENT: tangent_q  <= pwdata[TAN_W-1:0];
        REG_CODE0:   codes_q[0] <= pwdata[CODE_W-1:0];
        REG_CODE1:   codes_q[1] <= pwdata[CODE_W-1:0];
        REG_CODE2:   codes_q[2] <= pwdata[CODE_W-1:0];
        REG_CODE3:   codes_q[3] <= pwdata[CODE_W-1:0];
        default: ;  // addresses past the list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS:  prdata = DATA_W'(radius_q);
      REG_TANGENT: prdata = DATA_W'(tangent_q);
      REG_CODE0:   prdata = DATA_W'(codes_q[0]);
      REG_CODE1:   prdata = DATA_W'(codes_q[1]);
      REG_CODE2:   prdata = DATA_W'(codes_q[2]);
      REG_CODE3:   prdata = DATA_W'(codes_q[3]);
      default:     prdata = '0;
    endcase
  end

  // credit check: the queue must hold everything already in flight plus this item
  assign in_stall_o = ((QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(cls_valid)) >=
                      (QCNT_W+1)'(QUEUE_DEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;

  jgd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .x_sample_i   (x_sample_i),
    .y_sample_i   (y_sample_i),
    .radius_sq_i  (radius_q),
    .tangent_i    (tangent_q),
    .cls_valid_o  (cls_valid),
    .cls_region_o (cls_region)
  );

  // every classified item goes into the queue, between and repeats included
  assign q_push = cls_valid;

  jgd_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (q_push),
    .push_region_i (cls_region),
    .pop_i         (q_pop),
    .head_o        (q_head),
    .stat_o        (q_stat)
  );

  jgd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .codes_i        (codes_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .region_o       (out_region),
    .match_found_o  (match_found_o),
    .match_symbol_o (match_symbol_o)
  );

  assign region_o = 3'(out_region);

  // credit scheme keeps the queue from overflowing
  `JGD_ASSERT_IMPLIES(a_queue_no_overflow, q_push, !q_stat.full)
  // an accepted item reaches the queue in the cycle after it is accepted
  `JGD_ASSERT_NEXT(a_accept_reaches_queue, in_accept, q_push)
  // matches are only reported on a return to centre
  `JGD_ASSERT_IMPLIES(a_match_at_centre, out_valid_o && match_found_o, region_o == 3'(REGION_CENTRE))
  // no symbol without a match
  `JGD_ASSERT_IMPLIES(a_symbol_zero, out_valid_o && !match_found_o, match_symbol_o == '0)

endmodule

>>> dv/tb_top.sv
// self-checking bench for the joystick gesture decoder: directed sample table, then phases
// of random gestures under changing register settings, checked by a cycle-free predictor
// depends on jgd_pkg and the joystick_gesture_decoder top level
`timescale 1ns / 100ps

module tb_top;
  import jgd_pkg::*;

  localparam int RESET_CYCLES  = 8;
  // room for the pipeline of the block, plus margin for items that leave no result
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AFTER    = 300;
  localparam int PHASES        = 7;
  localparam int PHASE_TARGET  = 90;
  localparam int PHASE_ITEM_CAP = 135;

  // addresses past the register list, writes there must be ignored
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX  = 24'd8388608;
  localparam logic [TAN_W-1:0]    TANGENT_MAX = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] S_LO  = '0;
  localparam logic [SAMPLE_W-1:0] S_MID = SAMPLE_W'(CENTER);
  localparam logic [SAMPLE_W-1:0] S_HI  = '1;

  typedef struct packed {
    logic [2:0]       region;
    logic             found;
    logic [SYM_W-1:0] symbol;
  } gesture_report_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [2:0]          idx;
    logic [DATA_W-1:0]   value;
    logic [SAMPLE_W-1:0] xs;
    logic [SAMPLE_W-1:0] ys;
    gesture_report_t     report;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  // dut ports
  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [SAMPLE_W-1:0]  x_sample_i  = '0;
  logic [SAMPLE_W-1:0]  y_sample_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           region_o;
  logic                 match_found_o;
  logic [SYM_W-1:0]     match_symbol_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [ADDR_W-1:0]    paddr       = '0;
  logic [DATA_W-1:0]    pwdata      = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  joystick_gesture_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .x_sample_i     (x_sample_i),
    .y_sample_i     (y_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .region_o       (region_o),
    .match_found_o  (match_found_o),
    .match_symbol_o (match_symbol_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // mirror of the register file, updated at each completed write
  logic [RADIUS_W-1:0] mir_radius  = RADIUS_RESET;
  logic [TAN_W-1:0]    mir_tangent = TANGENT_RESET;
  code_entry_t         mir_code [NUM_CODE_REGS];

  // mirror of the gesture tracker
  region_e             trk_region = REGION_CENTRE;
  logic [DIR_W-1:0]    trk_dirs [MAX_GESTURE_LEN];
  logic [LEN_W-1:0]    trk_len = '0;
  logic                trk_ovf = 1'b0;

  // region reports still owed by the block, oldest first
  gesture_report_t     report_q [$];
  stim_row_t           stim_table [$];

  int errors           = 0;
  int samples_taken    = 0;
  int reports_owed     = 0;
  int reports_seen     = 0;
  int matches_owed     = 0;
  int settings_applied = 0;
  int phase_reports    = 0;
  int phase_items      = 0;
  int burst_left       = 8;

  // receiver side state
  gesture_report_t rx_want;
  stall_mode_e     stall_mode = STALL_NONE;
  int              mode_left  = 0;
  int              hold_left  = 0;
  bit              hold_done  = 1'b0;

  initial begin
    mir_code[0] = CODE0_RESET;
    mir_code[1] = CODE1_RESET;
    mir_code[2] = CODE2_RESET;
    mir_code[3] = CODE3_RESET;
    for (int i = 0; i < MAX_GESTURE_LEN; i++) trk_dirs[i] = '0;
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // strict sector test: across must stay below tangent times along
  function automatic bit in_sector(longint along, longint across, logic [TAN_W-1:0] tang);
    longint mag;
    mag = (across < 0) ? -across : across;
    if (along < 0) return 1'b0;
    return (mag * 65536) < (longint'(tang) * along);
  endfunction

  function automatic region_e classify_stick(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys);
    longint dx;
    longint dy;
    dx = longint'(xs) - CENTER;
    dy = longint'(ys) - CENTER;
    if (dx * dx + dy * dy < longint'(mir_radius)) return REGION_CENTRE;
    // dead centre outside a zero radius counts as angle zero
    if (dx == 0 && dy == 0) return REGION_RIGHT;
    if (in_sector(dx, dy, mir_tangent)) return REGION_RIGHT;
    if (in_sector(dy, dx, mir_tangent)) return REGION_UP;
    if (in_sector(-dx, dy, mir_tangent)) return REGION_LEFT;
    if (in_sector(-dy, dx, mir_tangent)) return REGION_DOWN;
    return REGION_BETWEEN;
  endfunction

  function automatic bit code_hits(code_entry_t e);
    if (e.length == 0 || e.length != trk_len) return 1'b0;
    for (int i = 0; i < MAX_GESTURE_LEN && i < int'(e.length); i++) begin
      if (e.dirs[2*i +: 2] != trk_dirs[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // one sample pair through the tracker; has_report tells whether a result is owed
  task automatic decode_gesture_step(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                                     output bit has_report, output gesture_report_t rep);
    region_e r;
    r = classify_stick(xs, ys);
    has_report = 1'b0;
    rep = '0;
    if (r != REGION_BETWEEN && r != trk_region) begin
      trk_region = r;
      has_report = 1'b1;
      rep.region = r;
      if (r == REGION_CENTRE) begin
        // overflowed or empty sequences match nothing, first entry wins
        if (!trk_ovf && trk_len != 0) begin
          for (int k = 0; k < CODE_ENTRIES; k++) begin
            if (!rep.found && code_hits(mir_code[k])) begin
              rep.found  = 1'b1;
              rep.symbol = mir_code[k].symbol;
            end
          end
        end
        trk_len = '0;
        trk_ovf = 1'b0;
      end else if (trk_len >= MAX_GESTURE_LEN) begin
        trk_ovf = 1'b1;
      end else begin
        trk_dirs[trk_len] = r[DIR_W-1:0];
        trk_len = trk_len + 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one item, hold it through stalls, then book what it owes;
  // typed rows carry their own expected report in place of the predicted one
  task automatic offer_sample(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                              input bit typed, input gesture_report_t typed_rep);
    bit has_report;
    gesture_report_t rep;
    int gap;
    in_valid_i <= 1'b1;
    x_sample_i <= xs;
    y_sample_i <= ys;
    do @(posedge clk_i); while (in_stall_o);
    decode_gesture_step(xs, ys, has_report, rep);
    samples_taken++;
    phase_items++;
    if (typed) report_q.push_back(typed_rep);
    else if (has_report) report_q.push_back(rep);
    if (has_report) begin
      reports_owed++;
      phase_reports++;
      if (rep.found) matches_owed++;
    end
    // burst pacing: a gap of zero keeps valid up into the next burst
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop offering, let every owed report out, then let the pipe run empty
  task automatic wait_block_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write followed by a read back of the same register, unless it lies past the list
  task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    wait_block_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_RADIUS:  begin mir_radius  = value[RADIUS_W-1:0]; mask = (1 << RADIUS_W) - 1; end
      REG_TANGENT: begin mir_tangent = value[TAN_W-1:0];    mask = (1 << TAN_W) - 1; end
      REG_CODE0, REG_CODE1, REG_CODE2, REG_CODE3: begin
        mir_code[idx - REG_CODE0] = value[CODE_W-1:0];
        mask = (1 << CODE_W) - 1;
      end
      default: mask = '0;
    endcase
    if (mask != 0) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if ((prdata & mask) != (value & mask))
        $error("register %0d read back: expected %0h, got %0h", idx, value & mask, prdata & mask);
      if ((prdata & mask) != (value & mask)) errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  // pick a stick position that should land in region r under the current tangent
  task automatic aim_stick(input region_e r, output logic [SAMPLE_W-1:0] xs,
                           output logic [SAMPLE_W-1:0] ys);
    int along;
    int across;
    int lim;
    int dx;
    int dy;
    along = $urandom_range(1100, 2047);
    lim = (along * int'(mir_tangent)) / 65536;
    across = (lim > 1) ? int'($urandom_range(0, lim - 1)) : 0;
    if ($urandom_range(0, 1)) across = -across;
    case (r)
      REGION_RIGHT:  begin dx = along;  dy = across; end
      REGION_UP:     begin dx = across; dy = along;  end
      REGION_LEFT:   begin dx = -along; dy = across; end
      REGION_DOWN:   begin dx = across; dy = -along; end
      REGION_CENTRE: begin
        dx = int'($urandom_range(0, 400)) - 200;
        dy = int'($urandom_range(0, 400)) - 200;
      end
      default: begin
        // on the diagonal, outside every sector whatever the tangent
        dx = $urandom_range(0, 1) ? along : -along;
        dy = $urandom_range(0, 1) ? along : -along;
      end
    endcase
    xs = clamp_sample(CENTER + dx);
    ys = clamp_sample(CENTER + dy);
  endtask

  task automatic offer_noise();
    offer_sample(SAMPLE_W'($urandom_range(0, 4095)), SAMPLE_W'($urandom_range(0, 4095)),
                 1'b0, '0);
  endtask

  // one gesture: mostly a stored code or a plausible path, then a return to centre
  task automatic run_gesture();
    logic [SAMPLE_W-1:0] xs;
    logic [SAMPLE_W-1:0] ys;
    region_e     path [10];
    code_entry_t e;
    int          len;
    int          d;
    int          prev;
    e = mir_code[$urandom_range(0, NUM_CODE_REGS - 1)];
    prev = -1;
    if ($urandom_range(0, 99) < 60 && e.length != 0 && e.length <= MAX_GESTURE_LEN) begin
      len = e.length;
      for (int i = 0; i < len; i++) path[i] = region_e'({1'b0, e.dirs[2*i +: 2]});
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        d = $urandom_range(0, 3);
        if (d == prev && $urandom_range(0, 9) != 0) d = (d + 1) % 4;
        path[i] = region_e'(d);
        prev = d;
      end
    end
    for (int i = 0; i < len; i++) begin
      aim_stick(path[i], xs, ys);
      offer_sample(xs, ys, 1'b0, '0);
      // dwelling in the same sector
      if ($urandom_range(0, 4) == 0) begin
        aim_stick(path[i], xs, ys);
        offer_sample(xs, ys, 1'b0, '0);
      end
      if ($urandom_range(0, 6) == 0) begin
        aim_stick(REGION_BETWEEN, xs, ys);
        offer_sample(xs, ys, 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) offer_noise();
    end
    if ($urandom_range(0, 99) < 85) begin
      aim_stick(REGION_CENTRE, xs, ys);
      offer_sample(xs, ys, 1'b0, '0);
    end
    if ($urandom_range(0, 9) == 0) offer_noise();
  endtask

  // table rows
  task automatic row_sample(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys);
    stim_row_t row;
    row = '0;
    row.kind = ROW_PREDICT;
    row.xs = xs;
    row.ys = ys;
    stim_table.push_back(row);
  endtask

  task automatic row_expect(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                            input region_e r, input logic found, input logic [SYM_W-1:0] sym);
    stim_row_t row;
    row = '0;
    row.kind = ROW_TYPED;
    row.xs = xs;
    row.ys = ys;
    row.report = '{region: r, found: found, symbol: sym};
    stim_table.push_back(row);
  endtask

  task automatic row_config(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.idx = idx;
    row.value = value;
    stim_table.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: checks each taken result and drives its own stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (report_q.size() == 0) begin
        $error("result with nothing expected: region %0d found %0d symbol %0h",
               region_o, match_found_o, match_symbol_o);
        errors++;
      end else begin
        rx_want = report_q.pop_front();
        reports_seen++;
        if (region_o !== rx_want.region) begin
          $error("region: expected %0d, got %0d", rx_want.region, region_o);
          errors++;
        end
        if (match_found_o !== rx_want.found) begin
          $error("match_found: expected %0d, got %0d", rx_want.found, match_found_o);
          errors++;
        end
        if (match_symbol_o !== rx_want.symbol) begin
          $error("match_symbol: expected %0h, got %0h", rx_want.symbol, match_symbol_o);
          errors++;
        end
      end
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      // one long hold-off so the region queue fills and the input backs up
      if (!hold_done && samples_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // watchdog: too long without any handshake on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, report_q.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    code_entry_t         fresh [NUM_CODE_REGS];
    logic [RADIUS_W-1:0] rad;
    logic [TAN_W-1:0]    tang;
    int                  choice;
    int                  d;
    int                  prev;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings; the codes decode as "01", "3012", "2103"
    row_expect(S_HI,  S_MID, REGION_RIGHT,  1'b0, 8'h00);
    row_sample(S_HI,  S_HI);                                 // corner, between sectors
    row_expect(S_MID, S_HI,  REGION_UP,     1'b0, 8'h00);
    row_expect(S_MID, S_MID, REGION_CENTRE, 1'b1, 8'h61);    // first code
    row_expect(S_MID, S_LO,  REGION_DOWN,   1'b0, 8'h00);
    row_sample(S_HI,  S_MID);
    row_sample(S_MID, S_HI);
    row_sample(S_LO,  S_MID);
    row_expect(S_MID, S_MID, REGION_CENTRE, 1'b1, 8'h62);    // second code
    // nine directions: the last one overflows the sequence
    row_expect(S_HI,  S_MID, REGION_RIGHT,  1'b0, 8'h00);
    row_sample(S_HI,  S_MID);                                // same region again
    row_sample(S_MID, S_HI);
    row_sample(S_LO,  S_LO);                                 // between
    row_sample(S_HI,  S_MID);
    row_sample(S_MID, S_HI);
    row_sample(S_HI,  S_MID);
    row_sample(S_MID, S_HI);
    row_sample(S_HI,  S_MID);
    row_sample(S_MID, S_HI);
    row_sample(S_HI,  S_MID);
    row_expect(S_MID, S_MID, REGION_CENTRE, 1'b0, 8'h00);    // overflowed, no match
    // zero radius: dead centre is not centred and reads as right
    row_config(REG_RADIUS, 32'd0);
    row_expect(S_MID, S_MID, REGION_RIGHT,  1'b0, 8'h00);
    row_sample(S_HI,  S_LO);
    // widest radius: only the far corner stays outside
    row_config(REG_RADIUS, 32'(RADIUS_MAX));
    row_sample(S_HI,  S_HI);
    row_expect(S_HI,  S_MID, REGION_CENTRE, 1'b0, 8'h00);    // one symbol, no code
    row_config(REG_RADIUS, 32'(RADIUS_RESET));
    // zero tangent closes every sector
    row_config(REG_TANGENT, 32'd0);
    row_sample(S_HI,  S_MID);
    row_config(REG_TANGENT, 32'(TANGENT_RESET));
    // writes past the register list change nothing
    row_config(REG_SPARE_A, 32'hFFFF_FFFF);
    row_config(REG_SPARE_B, 32'h0000_0000);
    row_sample(S_LO,  S_MID);
    row_sample(S_MID, S_MID);

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_CONFIG: write_register(stim_table[i].idx, stim_table[i].value);
        ROW_TYPED:  offer_sample(stim_table[i].xs, stim_table[i].ys, 1'b1, stim_table[i].report);
        default:    offer_sample(stim_table[i].xs, stim_table[i].ys, 1'b0, '0);
      endcase
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin rad = RADIUS_RESET; tang = TANGENT_RESET; end
        1:       begin rad = '0;           tang = TANGENT_MAX;   end
        2:       begin rad = RADIUS_MAX;   tang = TANGENT_RESET; end
        3:       begin
          rad  = RADIUS_W'($urandom_range(50000, 1500000));
          tang = TAN_W'($urandom_range(20000, 65535));
        end
        4:       begin rad = RADIUS_RESET; tang = '0;            end
        5:       begin rad = RADIUS_W'($urandom_range(0, RADIUS_MAX)); tang = TANGENT_MAX; end
        default: begin rad = RADIUS_RESET; tang = TAN_W'($urandom_range(0, 65535)); end
      endcase
      for (int k = 0; k < NUM_CODE_REGS; k++) begin
        choice = $urandom_range(0, 99);
        if (p == 0 || choice >= 92 || (choice >= 82 && k == 0)) begin
          case (k)
            0:       fresh[k] = CODE0_RESET;
            1:       fresh[k] = CODE1_RESET;
            2:       fresh[k] = CODE2_RESET;
            default: fresh[k] = CODE3_RESET;
          endcase
        end else if (choice < 72) begin
          fresh[k] = CODE_W'($urandom);
          if (choice < 45) begin
            // well-formed path with no direction repeated back to back
            prev = -1;
            for (int i = 0; i < CODE_DIRS; i++) begin
              d = $urandom_range(0, 3);
              if (d == prev) d = (d + int'($urandom_range(1, 3))) % 4;
              fresh[k].dirs[2*i +: 2] = d[1:0];
              prev = d;
            end
            fresh[k].length = LEN_W'($urandom_range(1, MAX_GESTURE_LEN));
          end else if (choice < 60) begin
            fresh[k].length = '0;
          end
        end else if (choice < 82) begin
          fresh[k] = CODE_W'($urandom);
          fresh[k].length = LEN_W'($urandom_range(MAX_GESTURE_LEN + 1, 15));
        end else begin
          // same path as an earlier entry under another symbol, first one wins
          fresh[k] = fresh[$urandom_range(0, k - 1)];
          fresh[k].symbol = SYM_W'($urandom_range(0, 255));
        end
      end
      write_register(REG_RADIUS,  {8'($urandom), rad});
      write_register(REG_TANGENT, {16'($urandom), tang});
      for (int k = 0; k < NUM_CODE_REGS; k++)
        write_register(3'(REG_CODE0 + k), {4'($urandom), fresh[k]});
      settings_applied++;
      phase_reports = 0;
      phase_items   = 0;
      while (phase_reports < PHASE_TARGET && phase_items < PHASE_ITEM_CAP) run_gesture();
    end

    wait_block_idle();

    $display("run covered %0d sample items over %0d register settings plus the directed table",
             samples_taken, settings_applied);
    $display("%0d region reports checked, %0d of them gesture matches",
             reports_seen, matches_owed);
    if (errors == 0 && reports_seen == reports_owed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
